// ----- rtl/core/lrsg_pkg.sv -----
// ----------------------------------------------------------------------------
// lrsg_pkg
// shared constants, types and helpers for the late reverb subtraction gain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lrsg_pkg;
	localparam int LRSG_MAX_BINS   = 1025;
	localparam int LRSG_MAX_DELAY  = 16;
	localparam int LRSG_POWER_BITS = 32;

	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [15:0] ONE_Q15 = 16'd32768;

	localparam int DIV_STEPS  = 31;
	localparam int SQRT_STEPS = 16;

	typedef enum logic [2:0] {
		REG_BINS   = 3'd0,
		REG_DELAY  = 3'd1,
		REG_DECAY  = 3'd2,
		REG_THRESH = 3'd3,
		REG_OVER   = 3'd4,
		REG_FLOOR  = 3'd5,
		REG_ATTEN  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [16:0] decay;
		logic [16:0] thresh;
		logic [16:0] over;
		logic [16:0] floor_r;
		logic [16:0] atten;
	} ratio_cfg_t;

	function automatic logic [16:0] clamp_q16(input logic [16:0] v);
		clamp_q16 = (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/core/lrsg_ram.sv -----
// ----------------------------------------------------------------------------
// lrsg_ram
// generic single-clock ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lrsg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/lrsg_gain.sv -----
// ----------------------------------------------------------------------------
// lrsg_gain
// pipelined gain arithmetic: late estimate, test, clean power, q30 ratio,
// square root and blend; with adv high, one cell per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lrsg_gain
	import lrsg_pkg::*;
#(
	parameter int POWER_BITS = LRSG_POWER_BITS
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  adv,
	input  wire                  in_vld,
	input  wire                  in_active,
	input  wire [POWER_BITS-1:0] in_p,
	input  wire [POWER_BITS-1:0] in_old,
	input  ratio_cfg_t           cfg,
	output logic                 out_vld,
	output logic [15:0]          out_gain,
	output logic                 out_supp
);
	localparam int PB  = POWER_BITS;
	localparam int NB  = PB + 1;        // remainder width
	localparam int NST = DIV_STEPS + SQRT_STEPS + 4;

	// stage a: late estimate and threshold product
	logic           va_q, acta_q;
	logic [PB-1:0]  pa_q;
	logic [PB:0]    latea_q;
	logic [PB:0]    thra_q;
	// stage b: test, sub and floor products
	logic           vb_q, actb_q, supb_q;
	logic [PB-1:0]  pb_q;
	logic [PB+5:0]  subb_q;
	logic [PB:0]    flrb_q;
	// stage c: clean
	logic           vc_q, supc_q;
	logic [PB-1:0]  pc_q;
	logic [PB-1:0]  cleanc_q;

	logic [16:0] dec_c, thr_c, ovr_c, flr_c, att_c;
	assign dec_c = clamp_q16(cfg.decay);
	assign thr_c = clamp_q16(cfg.thresh);
	assign ovr_c = clamp_q16(cfg.over);
	assign flr_c = clamp_q16(cfg.floor_r);
	assign att_c = clamp_q16(cfg.atten);

	logic [PB+16:0] late_m, thr_m, flr_m;
	logic [PB+17:0] sub_m;
	assign late_m = in_old * dec_c;
	assign thr_m  = in_p * thr_c;
	assign sub_m  = latea_q * ovr_c;
	assign flr_m  = pa_q * flr_c;

	logic [PB:0] clean_d;
	always_comb begin
		if (subb_q > {6'd0, pb_q}) begin
			clean_d = '0;
		end else begin
			clean_d = {1'b0, pb_q} - subb_q[PB:0];
		end
		if (flrb_q > clean_d) begin
			clean_d = flrb_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q <= 1'b0;
			vb_q <= 1'b0;
			vc_q <= 1'b0;
		end else if (adv) begin
			va_q <= in_vld;
			vb_q <= va_q;
			vc_q <= vb_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acta_q   <= in_active;
			pa_q     <= in_p;
			latea_q  <= late_m[PB+16:16];
			thra_q   <= thr_m[PB+16:16];
			actb_q   <= acta_q;
			supb_q   <= acta_q && (latea_q > thra_q);
			pb_q     <= pa_q;
			subb_q   <= sub_m[PB+17:12];
			flrb_q   <= flr_m[PB+16:16];
			supc_q   <= actb_q && supb_q;
			pc_q     <= pb_q;
			cleanc_q <= clean_d[PB-1:0];
		end
	end

	// restoring divider, one quotient bit per stage
	logic [NB-1:0]  drem  [DIV_STEPS];
	logic [30:0]    dquo  [DIV_STEPS];
	logic [PB-1:0]  dden  [DIV_STEPS];
	logic           dsup  [DIV_STEPS];
	logic           dvld  [DIV_STEPS];

	logic [NB-1:0] rem0;
	logic          q0;
	assign q0   = (cleanc_q >= pc_q);
	assign rem0 = q0 ? {1'b0, cleanc_q - pc_q} : {1'b0, cleanc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld[0] <= 1'b0;
		end else if (adv) begin
			dvld[0] <= vc_q;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			drem[0] <= rem0;
			dquo[0] <= {30'd0, q0};
			dden[0] <= pc_q;
			dsup[0] <= supc_q;
		end
	end

	for (genvar i = 0; i < DIV_STEPS - 1; i++) begin : g_div
		logic [NB:0] sh;
		logic        ge;
		assign sh = {drem[i], 1'b0};
		assign ge = sh >= {2'b0, dden[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld[i+1] <= 1'b0;
			end else if (adv) begin
				dvld[i+1] <= dvld[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				drem[i+1] <= ge ? (sh[NB-1:0] - {1'b0, dden[i]}) : sh[NB-1:0];
				dquo[i+1] <= {dquo[i][29:0], ge};
				dden[i+1] <= dden[i];
				dsup[i+1] <= dsup[i];
			end
		end
	end

	// restoring square root of the 31 bit q30 value, one result bit per stage
	logic [32:0] sv   [SQRT_STEPS+1];
	logic [17:0] sres [SQRT_STEPS+1];
	logic [17:0] srm  [SQRT_STEPS+1];
	logic        ssup [SQRT_STEPS+1];
	logic        svld [SQRT_STEPS+1];

	assign sv[0]   = {2'b0, dquo[DIV_STEPS-1]};
	assign sres[0] = '0;
	assign srm[0]  = '0;
	assign ssup[0] = dsup[DIV_STEPS-1];
	assign svld[0] = dvld[DIV_STEPS-1];

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		logic [19:0] trial;
		logic [19:0] rm2;
		logic [32:0] sv_q;
		logic [17:0] sres_q, srm_q;
		logic        ssup_q, svld_q;
		assign rm2   = {srm[j], sv[j][31:30]};
		assign trial = {sres[j], 2'b01};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				svld_q <= 1'b0;
			end else if (adv) begin
				svld_q <= svld[j];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sv_q   <= {sv[j][30:0], 2'b00};
				ssup_q <= ssup[j];
				if (rm2 >= trial) begin
					srm_q  <= 18'(rm2 - trial);
					sres_q <= {sres[j][16:0], 1'b1};
				end else begin
					srm_q  <= rm2[17:0];
					sres_q <= {sres[j][16:0], 1'b0};
				end
			end
		end
		assign sv[j+1]   = sv_q;
		assign sres[j+1] = sres_q;
		assign srm[j+1]  = srm_q;
		assign ssup[j+1] = ssup_q;
		assign svld[j+1] = svld_q;
	end

	// blend toward one
	logic [15:0] full;
	logic [15:0] rest;
	logic [16:0] inv_att;
	logic [32:0] blend_m;
	assign full    = (sres[SQRT_STEPS] > 18'(ONE_Q15)) ? ONE_Q15 : sres[SQRT_STEPS][15:0];
	assign rest    = ONE_Q15 - full;
	assign inv_att = ONE_Q16 - att_c;
	assign blend_m = inv_att * rest;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (adv) begin
			out_vld <= svld[SQRT_STEPS];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_supp <= ssup[SQRT_STEPS];
			out_gain <= ssup[SQRT_STEPS] ? 16'(full + blend_m[32:16]) : ONE_Q15;
		end
	end

	logic unused_ok;
	assign unused_ok = ^{NST, srm[SQRT_STEPS], sv[SQRT_STEPS], dquo[DIV_STEPS-1][30],
		drem[DIV_STEPS-1], dden[DIV_STEPS-1], actb_q};
endmodule
`default_nettype wire

// ----- rtl/core/late_reverb_subtraction_gain.sv -----
// ----------------------------------------------------------------------------
// late_reverb_subtraction_gain
// late reverberation spectral subtraction gain per stft power cell
// ----------------------------------------------------------------------------
// channel | direction | handshake        | payload
// in      | input     | in_valid/in_stall   | cell_power, bin_index, clip_start
// out     | output    | out_valid/out_stall | cell_gain, suppressed
// cfg     | input     | apb write/read   | seven registers at 4*i
//
// one request per cycle while out_stall is low; cells pass stage 1, three
// product and clean stages, 31 divider stages, 16 square root stages and the
// output register. history lives in one ram with a registered read; the ram
// is written at the accepting edge, so the next read of that entry sees it.
// reset clears control state only; the history ram is undefined until written.
// out_stall freezes the whole pipeline and raises in_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module late_reverb_subtraction_gain
	import lrsg_pkg::*;
#(
	parameter int MAX_BINS   = LRSG_MAX_BINS,
	parameter int MAX_DELAY  = LRSG_MAX_DELAY,
	parameter int POWER_BITS = LRSG_POWER_BITS
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [31:0] cell_power,
	input  wire  [10:0] bin_index,
	input  wire         clip_start,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [15:0] cell_gain,
	output logic        suppressed,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [4:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int BW  = $clog2(MAX_BINS);
	localparam int SW  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
	localparam int FW  = $clog2(MAX_DELAY + 1);
	localparam int DEP = MAX_BINS * MAX_DELAY;
	localparam int AW  = $clog2(DEP);

	logic [10:0] bins_q;
	logic [4:0]  delay_q;
	ratio_cfg_t  rcfg_q;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q         <= 11'd1025;
			delay_q        <= 5'd4;
			rcfg_q.decay   <= 17'd16384;
			rcfg_q.thresh  <= 17'd32768;
			rcfg_q.over    <= 17'd4096;
			rcfg_q.floor_r <= 17'd6554;
			rcfg_q.atten   <= 17'd65536;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:2])
				REG_BINS:   bins_q         <= pwdata[10:0];
				REG_DELAY:  delay_q        <= pwdata[4:0];
				REG_DECAY:  rcfg_q.decay   <= pwdata[16:0];
				REG_THRESH: rcfg_q.thresh  <= pwdata[16:0];
				REG_OVER:   rcfg_q.over    <= pwdata[16:0];
				REG_FLOOR:  rcfg_q.floor_r <= pwdata[16:0];
				REG_ATTEN:  rcfg_q.atten   <= pwdata[16:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (paddr[4:2])
			REG_BINS:   prdata = {21'd0, bins_q};
			REG_DELAY:  prdata = {27'd0, delay_q};
			REG_DECAY:  prdata = {15'd0, rcfg_q.decay};
			REG_THRESH: prdata = {15'd0, rcfg_q.thresh};
			REG_OVER:   prdata = {15'd0, rcfg_q.over};
			REG_FLOOR:  prdata = {15'd0, rcfg_q.floor_r};
			REG_ATTEN:  prdata = {15'd0, rcfg_q.atten};
			default:    prdata = '0;
		endcase
	end

	logic [11:0] bins_e;
	logic [8:0]  dly_e;
	always_comb begin
		bins_e = {1'b0, bins_q};
		if (bins_e < 12'd1) bins_e = 12'd1;
		if (bins_e > 12'(MAX_BINS)) bins_e = 12'(MAX_BINS);
		dly_e = {4'd0, delay_q};
		if (dly_e < 9'd1) dly_e = 9'd1;
		if (dly_e > 9'(MAX_DELAY)) dly_e = 9'(MAX_DELAY);
	end

	logic adv;
	assign adv      = !out_stall;
	assign in_stall = out_stall;

	logic acc;
	assign acc = in_valid && adv;

	// slot/fill control
	logic [SW-1:0] slot_q;
	logic [FW-1:0] fill_q;
	logic [SW-1:0] slot_c;
	logic [FW-1:0] fill_c;
	logic          inrange;
	assign slot_c  = clip_start ? '0 : slot_q;
	assign fill_c  = clip_start ? '0 : fill_q;
	assign inrange = {1'b0, bin_index} < bins_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
		end else if (acc) begin
			slot_q <= slot_c;
			fill_q <= fill_c;
			if (inrange && ({1'b0, bin_index} == bins_e - 12'd1)) begin
				slot_q <= (9'(slot_c) + 9'd1 >= dly_e) ? '0 : SW'(slot_c + 1'b1);
				if (9'(fill_c) < dly_e) fill_q <= FW'(fill_c + 1'b1);
			end
		end
	end

	// history ram, read and write the same entry (read first, then overwrite)
	logic [AW-1:0]         addr;
	logic [POWER_BITS-1:0] raw;
	logic [POWER_BITS-1:0] rdata;
	assign raw  = cell_power[POWER_BITS-1:0];
	assign addr = AW'(slot_c * MAX_BINS) + AW'(bin_index[BW-1:0]);

	logic [POWER_BITS-1:0] hold_q;
	logic                  use_hold_q;

	lrsg_ram #(.WIDTH(POWER_BITS), .DEPTH(DEP)) u_hist (
		.clk   (clk),
		.we    (acc && inrange),
		.waddr (addr),
		.wdata (raw),
		.re    (adv),
		.raddr (addr),
		.rdata (rdata)
	);

	// stage 1: registered cell info alongside ram read
	logic                  v_s1, act_s1, has_s1;
	logic [POWER_BITS-1:0] p_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1 <= inrange;
			has_s1 <= 9'(fill_c) >= dly_e;
			p_s1   <= (raw == '0) ? POWER_BITS'(1) : raw;
		end
	end

	// ram output holds under a stall, as re is low then; a copy is kept as well
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_hold_q <= 1'b0;
		end else begin
			use_hold_q <= !adv;
		end
	end
	always_ff @(posedge clk) begin
		if (!use_hold_q) hold_q <= rdata;
	end

	logic [POWER_BITS-1:0] old;
	assign old = has_s1 ? (use_hold_q ? hold_q : rdata) : '0;

	lrsg_gain #(.POWER_BITS(POWER_BITS)) u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_vld    (v_s1),
		.in_active (act_s1),
		.in_p      (p_s1),
		.in_old    (old),
		.cfg       (rcfg_q),
		.out_vld   (out_valid),
		.out_gain  (cell_gain),
		.out_supp  (suppressed)
	);
endmodule
`default_nettype wire

// ----- tb/lrsg_checker.sv -----
// ----------------------------------------------------------------------------
// lrsg_checker
// follows register writes and accepted cells, works out the gain of every
// cell from its own copy of the power history, compares each delivered gain
// in order and counts the failures
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lrsg_checker
	import lrsg_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire  [31:0] cell_power,
	input  wire  [10:0] bin_index,
	input  wire         clip_start,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire  [15:0] cell_gain,
	input  wire         suppressed,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [4:0]  paddr,
	input  wire  [31:0] pwdata,
	input  wire         pready,
	output int          gains_pending,
	output int          fail_count
);
	typedef struct packed {
		logic [15:0] gain;
		logic        supp;
	} cell_gain_t;

	logic [31:0] history [LRSG_MAX_DELAY][LRSG_MAX_BINS];
	logic [16:0] regs [7];
	int unsigned cur_slot;
	int unsigned frames_seen;
	cell_gain_t  gain_q [$];

	function automatic longint unsigned lim_q16(input logic [16:0] v);
		lim_q16 = (v > ONE_Q16) ? 65536 : longint'(v);
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		floor_sqrt = r;
	endfunction

	function automatic cell_gain_t cell_gain_of(input logic [31:0] raw, input logic [10:0] bin,
			input logic clip);
		cell_gain_t res;
		int unsigned nb;
		int unsigned nd;
		longint unsigned p, old, late, sub, clean, flr, full, att;
		nb = regs[REG_BINS];
		nd = regs[REG_DELAY];
		if (nb < 1) nb = 1;
		if (nb > LRSG_MAX_BINS) nb = LRSG_MAX_BINS;
		if (nd < 1) nd = 1;
		if (nd > LRSG_MAX_DELAY) nd = LRSG_MAX_DELAY;
		res.gain = ONE_Q15;
		res.supp = 1'b0;
		if (clip) begin
			cur_slot = 0;
			frames_seen = 0;
		end
		if (bin >= nb)
			return res;
		p = (raw == 0) ? 1 : longint'(raw);
		old = (frames_seen >= nd) ? longint'(history[cur_slot][bin]) : 0;
		late = (old * lim_q16(regs[REG_DECAY])) >> 16;
		if (late > ((lim_q16(regs[REG_THRESH]) * p) >> 16)) begin
			sub = (lim_q16(regs[REG_OVER]) * late) >> 12;
			clean = (sub > p) ? 0 : p - sub;
			flr = (lim_q16(regs[REG_FLOOR]) * p) >> 16;
			if (flr > clean) clean = flr;
			full = floor_sqrt((clean << 30) / p);
			if (full > 32768) full = 32768;
			att = lim_q16(regs[REG_ATTEN]);
			res.gain = 16'(full + (((65536 - att) * (32768 - full)) >> 16));
			res.supp = 1'b1;
		end
		history[cur_slot][bin] = raw;
		if (bin == nb - 1) begin
			cur_slot = (cur_slot + 1 >= nd) ? 0 : cur_slot + 1;
			if (frames_seen < nd) frames_seen++;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cell_gain_t want;
		if (!arst_n) begin
			regs[REG_BINS]   <= 17'd1025;
			regs[REG_DELAY]  <= 17'd4;
			regs[REG_DECAY]  <= 17'd16384;
			regs[REG_THRESH] <= 17'd32768;
			regs[REG_OVER]   <= 17'd4096;
			regs[REG_FLOOR]  <= 17'd6554;
			regs[REG_ATTEN]  <= 17'd65536;
			cur_slot = 0;
			frames_seen = 0;
			fail_count <= 0;
			gains_pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_BINS:  regs[REG_BINS]  <= {6'd0, pwdata[10:0]};
					REG_DELAY: regs[REG_DELAY] <= {12'd0, pwdata[4:0]};
					REG_DECAY, REG_THRESH, REG_OVER, REG_FLOOR, REG_ATTEN: begin
						regs[paddr[4:2]] <= pwdata[16:0];
					end
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				gain_q = {gain_q, cell_gain_of(cell_power, bin_index, clip_start)};
			if (out_valid && !out_stall) begin
				if (gain_q.size() == 0) begin
					$display("%0t: unexpected gain, expected none, actual %0d/%0b", $time,
						cell_gain, suppressed);
					fail_count <= fail_count + 1;
				end else begin
					want = gain_q.pop_front();
					if (want.gain !== cell_gain || want.supp !== suppressed) begin
						$display("%0t: gain expected %0d/%0b, actual %0d/%0b", $time,
							want.gain, want.supp, cell_gain, suppressed);
						fail_count <= fail_count + 1;
					end
				end
			end
			gains_pending <= gain_q.size();
		end
	end
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives whole frames of power cells with noise bins and clip restarts
// through many register settings, with random gaps and output stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import lrsg_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] cell_power;
	logic [10:0] bin_index;
	logic        clip_start;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] cell_gain;
	logic        suppressed;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          gains_pending;
	int          fail_count;
	int          cycles;
	bit          quiet;

	late_reverb_subtraction_gain dut (.*);
	lrsg_checker checker_i (.*);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("late_reverb_subtraction_gain: mismatch");
			$finish;
		end
	end

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 5'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (gains_pending != 0);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_all(input int nb, nd, dec, thr, ovr, flo, att);
		settle();
		reg_write(REG_BINS, nb);
		reg_write(REG_DELAY, nd);
		reg_write(REG_DECAY, dec);
		reg_write(REG_THRESH, thr);
		reg_write(REG_OVER, ovr);
		reg_write(REG_FLOOR, flo);
		reg_write(REG_ATTEN, att);
	endtask

	task automatic send_cell(input logic [31:0] pw, input logic [10:0] bin, input logic clip);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cell_power <= pw;
		bin_index <= bin;
		clip_start <= clip;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic logic [31:0] rand_power();
		if ($urandom_range(0, 15) == 0)
			return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
		return $urandom >> $urandom_range(0, 31);
	endfunction

	function automatic int rand_ratio();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 65536;
			2: return 131071;
			default: return $urandom_range(0, 65536);
		endcase
	endfunction

	// whole frames, clip restarts only on bin 0, noise bins never touch history
	task automatic run_clip(input int nb, input int frames);
		for (int f = 0; f < frames; f++)
			for (int b = 0; b < nb; b++) begin
				if ($urandom_range(0, 19) == 0)
					send_cell(rand_power(), 11'($urandom_range(nb, 2047)), 1'b0);
				send_cell(rand_power(), 11'(b), (f == 0 && b == 0) ||
					(b == 0 && $urandom_range(0, 29) == 0));
			end
	endtask

	initial begin
		int nb, nd, eb, ed;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		cell_power <= '0;
		bin_index <= '0;
		clip_start <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cycles <= 0;
		quiet = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: strong history against weak cells, noise bins, zero power
		set_all(4, 2, 65536, 0, 65536, 0, 65536);
		send_cell(32'd0, 11'd0, 1'b1);
		send_cell(32'hFFFF_FFFF, 11'd1, 1'b0);
		send_cell(32'd1, 11'd2, 1'b0);
		send_cell(32'h8000_0000, 11'd3, 1'b0);
		send_cell(32'd5, 11'd2047, 1'b0);
		send_cell(32'd7, 11'd0, 1'b0);
		send_cell(32'd9, 11'd1, 1'b0);
		send_cell(32'd11, 11'd2, 1'b0);
		send_cell(32'd13, 11'd3, 1'b0);
		send_cell(32'hFFFF_FFFF, 11'd0, 1'b0);
		send_cell(32'd0, 11'd1, 1'b0);
		send_cell(32'hFFFF_FFFF, 11'd2, 1'b0);
		send_cell(32'd1, 11'd3, 1'b0);
		send_cell(32'd3, 11'd4, 1'b0);
		send_cell(32'd1000, 11'd0, 1'b0);
		send_cell(32'd1, 11'd1, 1'b0);
		send_cell(32'h0000_FFFF, 11'd2, 1'b1);
		send_cell(32'd2, 11'd0, 1'b1);

		set_all(0, 0, 131071, 131071, 131071, 131071, 131071);
		run_clip(1, 6);
		set_all(3, 31, 65536, 16384, 65536, 65536, 0);
		run_clip(3, 20);
		// top bins of a full-width frame, clip opened at bin 1020
		set_all(1025, 1, 65536, 32768, 8192, 6554, 32768);
		for (int f = 0; f < 3; f++)
			for (int b = 1020; b < 1025; b++)
				send_cell(rand_power(), 11'(b), (f == 0 && b == 1020));
		send_cell(32'd1, 11'd1024, 1'b0);
		send_cell(32'd1, 11'd0, 1'b0);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5) quiet = 1'b1;
			nb = $urandom_range(0, 12);
			nd = $urandom_range(0, 17);
			eb = (nb < 1) ? 1 : nb;
			ed = (nd < 1) ? 1 : (nd > 16 ? 16 : nd);
			set_all(nb, nd, rand_ratio(), rand_ratio(), rand_ratio(), rand_ratio(),
				rand_ratio());
			run_clip(eb, (ed + 2 > 60 / eb) ? ed + 2 : 60 / eb);
		end

		settle();
		if (fail_count == 0)
			$display("late_reverb_subtraction_gain: match");
		else
			$display("late_reverb_subtraction_gain: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
